@@ sv/waip_pkg.sv @@
package waip_pkg;

  localparam int unsigned BufDepth = 28;
  localparam int unsigned NumRows  = 9;

  localparam logic [27:0] Max28 = 28'hFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_PRD,
    ST_PACK,
    ST_OUT
  } waip_state_t;

  // Control group from the sequencer to the pending-value buffer.
  typedef struct packed {
    logic       wr_en;
    logic [4:0] wr_addr;
    logic [4:0] rd_addr;
  } waip_buf_ctrl_t;

  function automatic logic [4:0] row_width(input logic [3:0] r);
    logic [4:0] w;
    unique case (r)
      4'd0:    w = 5'd1;
      4'd1:    w = 5'd2;
      4'd2:    w = 5'd3;
      4'd3:    w = 5'd4;
      4'd4:    w = 5'd5;
      4'd5:    w = 5'd7;
      4'd6:    w = 5'd9;
      4'd7:    w = 5'd14;
      default: w = 5'd28;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] row_count(input logic [3:0] r);
    logic [4:0] c;
    unique case (r)
      4'd0:    c = 5'd28;
      4'd1:    c = 5'd14;
      4'd2:    c = 5'd9;
      4'd3:    c = 5'd7;
      4'd4:    c = 5'd5;
      4'd5:    c = 5'd4;
      4'd6:    c = 5'd3;
      4'd7:    c = 5'd2;
      default: c = 5'd1;
    endcase
    return c;
  endfunction

  function automatic logic [27:0] row_mask(input logic [3:0] r);
    logic [27:0] m;
    unique case (r)
      4'd0:    m = 28'h000_0001;
      4'd1:    m = 28'h000_0003;
      4'd2:    m = 28'h000_0007;
      4'd3:    m = 28'h000_000F;
      4'd4:    m = 28'h000_001F;
      4'd5:    m = 28'h000_007F;
      4'd6:    m = 28'h000_01FF;
      4'd7:    m = 28'h000_3FFF;
      default: m = Max28;
    endcase
    return m;
  endfunction

  // Circular index: the first operand stays below the depth and the second at most equal to it, so one subtract wraps.
  function automatic logic [4:0] wrap_add(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(BufDepth)) begin
      s = s - 6'(BufDepth);
    end
    return s[4:0];
  endfunction

endpackage

@@ sv/waip_buf.sv @@
module waip_buf
  import waip_pkg::*;
(
  input  logic           clk,
  input  waip_buf_ctrl_t ctrl,
  input  logic [27:0]    wr_data,
  output logic [27:0]    rd_data_r
);

  logic [27:0] mem [BufDepth];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[ctrl.rd_addr];
  end

endmodule

@@ sv/word_aligned_int_packer.sv @@
// Channel | Dir | Handshake               | Payload
// in_     | in  | in_tvalid / in_tready   | in_tdata = value, in_tlast = list_end
// out_    | out | out_tvalid / out_tready | out_tdata = packed_word, values_in_word;
//         |     |                         | out_tlast = final_word, out_tuser = oversize_seen
//
// A request that neither fills the buffer nor ends its list leaves the packer idle.
// The selector search reads each value from the buffer, then compares it, and checks
// the same value again against the next row when a row is rejected; packing reads
// each value taken, then shifts it in; the finished word is held until taken. These steps
// are set by the single registered read port of the pending buffer and the one shifter.
// Reset (rst_n low, synchronous) empties the buffer and clears the oversize flag.
// in_tready is high only while no word is being built or held; a held word
// waits in the output register until out_tready takes it.
module word_aligned_int_packer
  import waip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] packed_word, [36:32] values_in_word, [39:37] zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] oversize_seen
);

  waip_state_t state_r, state_nxt;

  // Pending buffer bookkeeping: entries head_r .. head_r + cnt_r - 1 (circular).
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  head_r, head_nxt;
  logic        ovf_r, ovf_nxt;
  logic        end_r, end_nxt;

  // Sequencer registers for the selector search and the packing pass; idx_r is shared by both.
  logic [4:0]  idx_r, idx_nxt;
  logic [3:0]  row_r, row_nxt;
  logic [3:0]  sel_r, sel_nxt;
  logic [4:0]  take_r, take_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [31:0] word_r, word_nxt;

  logic [31:0] out_word_r;
  logic [4:0]  out_cnt_r;
  logic        out_final_r;
  logic        out_ovf_r;
  logic        load_out;

  waip_buf_ctrl_t buf_ctrl;
  logic [27:0]    wr_data;
  logic [27:0]    rd_data_r;

  logic           in_fire;
  logic           in_big;
  logic [4:0]     row_n;
  logic [31:0]    shifted;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign in_big  = |in_tdata[31:28];
  assign wr_data = in_big ? Max28 : in_tdata[27:0];

  // Values a row may take: its slot count, or fewer when fewer are pending.
  assign row_n = (row_count(row_r) < cnt_r) ? row_count(row_r) : cnt_r;

  // The one shifter that places each value into its slot of the word.
  assign shifted = {4'b0, rd_data_r & row_mask(sel_r)} << sh_r[4:0];

  waip_buf u_buf (
    .clk       (clk),
    .ctrl      (buf_ctrl),
    .wr_data   (wr_data),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      head_r  <= '0;
      ovf_r   <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      ovf_r   <= ovf_nxt;
      end_r   <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    row_r  <= row_nxt;
    sel_r  <= sel_nxt;
    take_r <= take_nxt;
    sh_r   <= sh_nxt;
    word_r <= word_nxt;
    if (load_out) begin
      out_word_r  <= word_nxt;
      out_cnt_r   <= take_r;
      out_final_r <= end_r && (cnt_r == take_r);
      out_ovf_r   <= ovf_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    ovf_nxt   = ovf_r;
    end_nxt   = end_r;
    idx_nxt   = idx_r;
    row_nxt   = row_r;
    sel_nxt   = sel_r;
    take_nxt  = take_r;
    sh_nxt    = sh_r;
    word_nxt  = word_r;
    load_out  = 1'b0;
    out_tvalid = 1'b0;
    buf_ctrl.wr_en   = 1'b0;
    buf_ctrl.wr_addr = wrap_add(head_r, cnt_r);
    buf_ctrl.rd_addr = wrap_add(head_r, idx_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          buf_ctrl.wr_en = 1'b1;
          cnt_nxt = cnt_r + 5'd1;
          ovf_nxt = ovf_r | in_big;
          end_nxt = in_tlast;
          if (in_tlast || (cnt_r == 5'(BufDepth - 1))) begin
            idx_nxt   = '0;
            row_nxt   = '0;
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (idx_r >= row_n) begin
          // Every value this row needs has fit: the row is the selector.
          sel_nxt   = row_r;
          take_nxt  = row_n;
          idx_nxt   = '0;
          sh_nxt    = 6'd4;
          word_nxt  = {28'b0, row_r};
          state_nxt = ST_PRD;
        end else if ((rd_data_r & ~row_mask(row_r)) == '0) begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = ST_SRD;
        end else begin
          // Earlier values fit the narrower row, so they fit the next one;
          // only the current value is checked again.
          row_nxt = row_r + 4'd1;
        end
      end
      ST_PRD: begin
        state_nxt = ST_PACK;
      end
      ST_PACK: begin
        word_nxt = word_r | shifted;
        sh_nxt   = sh_r + {1'b0, row_width(sel_r)};
        if (idx_r + 5'd1 == take_r) begin
          load_out  = 1'b1;
          head_nxt  = wrap_add(head_r, take_r);
          cnt_nxt   = cnt_r - take_r;
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 5'd1;
          state_nxt = ST_PRD;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (end_r && (cnt_r != '0)) begin
            idx_nxt   = '0;
            row_nxt   = '0;
            state_nxt = ST_SRD;
          end else begin
            if (end_r) begin
              ovf_nxt = 1'b0;
              end_nxt = 1'b0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tdata = {3'b0, out_cnt_r, out_word_r};
  assign out_tlast = out_final_r;
  assign out_tuser = out_ovf_r;

  a_no_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input accepted while a word is held");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(BufDepth))
    else $error("pending count above buffer depth");

  a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:32] != 5'd0) && (out_tdata[36:32] <= 5'(BufDepth)))
    else $error("word holds an impossible number of values");

  a_selector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'(NumRows - 1))
    else $error("selector out of range");

  a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (cnt_r == '0))
    else $error("final word leaves values pending");

endmodule
